@@ design/bhpq_pkg.sv @@
// Package for the binary heap priority queue: payload structs, status and
// action codes, controller states and datapath operations.
// No dependencies.
package bhpq_pkg;

  localparam int KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 5;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic action;
    key_t key_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                key_out;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LD,
    S_DN_RD,
    S_DN_CMP,
    S_REPORT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_UP_READ,
    OP_UP_STEP,
    OP_RM_LOAD,
    OP_DN_READ,
    OP_DN_STEP,
    OP_REPORT
  } dp_op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_is_root;
    logic up_move;
    logic dn_move;
    logic count_zero;
  } dp_stat_t;

  // True when key a belongs strictly nearer the root than key b.
  function automatic logic ranks_above(logic order_is_max, key_t a, key_t b);
    ranks_above = order_is_max ? (a > b) : (a < b);
  endfunction

endpackage

@@ design/bhpq_ctrl.sv @@
// Controller state machine of the heap queue: sequences sift-up and
// sift-down steps. Depends on bhpq_pkg.
module bhpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              action,
  input  bhpq_pkg::dp_stat_t stat,
  output bhpq_pkg::dp_op_t   op,
  output logic              busy
);
  import bhpq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op = OP_START;
          if (action == ACT_INSERT) begin
            state_nxt = stat.full ? S_REPORT : S_UP_RD;
          end else begin
            state_nxt = stat.empty ? S_REPORT : S_RM_LD;
          end
        end
      end
      S_UP_RD: begin
        op        = OP_UP_READ;
        state_nxt = stat.pos_is_root ? S_REPORT : S_UP_CMP;
      end
      S_UP_CMP: begin
        op        = OP_UP_STEP;
        state_nxt = stat.up_move ? S_UP_RD : S_REPORT;
      end
      S_RM_LD: begin
        op        = OP_RM_LOAD;
        state_nxt = stat.count_zero ? S_REPORT : S_DN_RD;
      end
      S_DN_RD: begin
        op        = OP_DN_READ;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        op        = OP_DN_STEP;
        state_nxt = stat.dn_move ? S_DN_RD : S_REPORT;
      end
      S_REPORT: begin
        op        = OP_REPORT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bhpq_dp.sv @@
// Datapath of the heap queue: key store with two registered read ports,
// moving-key and hole registers, count, order register and result register.
// Depends on bhpq_pkg.
module bhpq_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bhpq_pkg::dp_op_t    op,
  input  bhpq_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_data,
  output bhpq_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output bhpq_pkg::out_item_t out_item
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = AW + 2;

  key_t mem [CAPACITY];
  key_t rd_a_r, rd_b_r;

  key_t                key_r, key_nxt;
  key_t                removed_r, removed_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                order_r;
  out_item_t           out_r;
  logic                out_valid_r;

  logic          mem_we;
  logic [AW-1:0] wr_addr, ra_a, ra_b;
  key_t          wr_data;

  logic [AW-1:0] parent;
  logic [DW-1:0] left_w, right_w;
  logic          left_better, right_better;
  key_t          best_val;

  assign parent  = AW'((pos_r - AW'(1)) >> 1);
  assign left_w  = (DW'(pos_r) << 1) + DW'(1);
  assign right_w = (DW'(pos_r) << 1) + DW'(2);

  always_comb begin
    left_better  = (left_w < DW'(count_r)) && ranks_above(order_r, rd_a_r, key_r);
    best_val     = left_better ? rd_a_r : key_r;
    right_better = (right_w < DW'(count_r)) && ranks_above(order_r, rd_b_r, best_val);
  end

  assign stat.full        = (count_r == CW'(CAPACITY));
  assign stat.empty       = (count_r == '0);
  assign stat.pos_is_root = (pos_r == '0);
  assign stat.up_move     = ranks_above(order_r, key_r, rd_a_r);
  assign stat.dn_move     = left_better || right_better;
  assign stat.count_zero  = (count_r == '0);

  always_comb begin
    key_nxt     = key_r;
    removed_nxt = removed_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    wr_addr     = pos_r;
    wr_data     = key_r;
    ra_a        = '0;
    ra_b        = '0;
    case (op)
      OP_START: begin
        status_nxt  = ST_OK;
        removed_nxt = '0;
        if (in_item.action == ACT_INSERT) begin
          if (stat.full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            key_nxt   = in_item.key_in;
            pos_nxt   = AW'(count_r);
            count_nxt = count_r + CW'(1);
          end
        end else begin
          if (stat.empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ra_b      = AW'(count_r - CW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
      end
      OP_UP_READ: begin
        ra_a   = parent;
        mem_we = stat.pos_is_root;
      end
      OP_UP_STEP: begin
        mem_we = 1'b1;
        if (stat.up_move) begin
          wr_data = rd_a_r;
          pos_nxt = parent;
        end
      end
      OP_RM_LOAD: begin
        removed_nxt = rd_a_r;
        key_nxt     = rd_b_r;
        pos_nxt     = '0;
      end
      OP_DN_READ: begin
        ra_a = left_w[AW-1:0];
        ra_b = right_w[AW-1:0];
      end
      OP_DN_STEP: begin
        mem_we = 1'b1;
        if (right_better) begin
          wr_data = rd_b_r;
          pos_nxt = right_w[AW-1:0];
        end else if (left_better) begin
          wr_data = rd_a_r;
          pos_nxt = left_w[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // key store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= (op == OP_REPORT);
      if (cfg_we) begin
        order_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    removed_r <= removed_nxt;
    pos_r     <= pos_nxt;
    status_r  <= status_nxt;
    if (op == OP_REPORT) begin
      out_r.status    <= status_r;
      out_r.key_out   <= removed_r;
      out_r.occupancy <= OCC_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ design/binary_heap_priority_queue.sv @@
// Top level of the binary heap priority queue of signed 32-bit keys.
// Instantiates bhpq_ctrl and bhpq_dp; depends on bhpq_pkg.
//
//  channel   ports                          transfer when
//  -------   -----------------------------  -------------------------
//  input     start, busy, in_item           start && !busy
//  result    out_valid, out_item            out_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// One item at a time. An insert climbs its key k levels toward the root
// (k <= log2(CAPACITY)); a remove moves the tail key to the root and sinks
// it, and a remove that empties the store skips the sift. A rejected item
// (full insert, empty remove) goes straight to its result. Each level costs
// a registered read of the key store and a compare-and-write step.
// rst_n is synchronous and clears the count, the order and the strobe; the
// key store is not cleared. The receiver cannot stall: each result shows
// for exactly one cycle, and busy is low in the cycle it appears.
module binary_heap_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output bhpq_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import bhpq_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  // Accept order changes only between items.
  assign cfg_ready = !busy;

  // Sequence the sift steps.
  bhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_item.action),
    .stat   (stat),
    .op     (op),
    .busy   (busy)
  );

  // Hold the keys, move the hole, build the result.
  bhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after item transfer");

  // A result strobe is never followed by another in the next cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // An overflow is reported only with the store full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OVERFLOW |->
      out_item.occupancy == OCC_W'(CAPACITY))
    else $error("overflow reported below capacity");

  // A failed item returns a zero key.
  a_fail_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.key_out == '0)
    else $error("nonzero key on failed item");

endmodule
